// ===== rtl/core/pfgp_pkg.sv =====
package pfgp_pkg;

  localparam int COLUMNS_DEF = 128;
  localparam int PAGES_DEF   = 8;

  // Operation codes
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_POINT = 2'd1;
  localparam logic [1:0] OP_GLYPH = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  typedef struct packed {
    logic [1:0] operation;
    logic [6:0] x;
    logic [5:0] y;
    logic       pixel_on;
    logic [2:0] column_index;
    logic [7:0] glyph_upper;
    logic [7:0] glyph_lower;
    logic [2:0] read_page;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       ignored;
  } result_t;

endpackage

// ===== rtl/core/pfgp_ram.sv =====
module pfgp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/pfgp_ctrl.sv =====
module pfgp_ctrl #(
  parameter int COLUMNS = pfgp_pkg::COLUMNS_DEF,
  parameter int PAGES   = pfgp_pkg::PAGES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  pfgp_pkg::item_t   item,
  output logic              res_valid,
  input  logic              res_ready,
  output pfgp_pkg::result_t res
);

  import pfgp_pkg::*;

  localparam int DEPTH  = PAGES * COLUMNS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int ROWS   = PAGES * 8;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_ACCESS = 2'd1;
  localparam logic [1:0] S_CLEAR  = 2'd2;

  logic [1:0]        state;
  logic [ADDR_W-1:0] clr_addr;
  logic              clr_reply;
  logic [1:0]        issue_cnt;
  logic              pend;
  logic              is_read;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic [2:0][7:0]   mask_q;
  logic [2:0][7:0]   data_q;
  logic [7:0]        res_data;
  logic              res_ign;

  // decode of the item presented at the input
  logic [2:0]        off;
  logic [2:0][7:0]   m_dec;
  logic [2:0][7:0]   d_dec;
  logic [7:0]        col_pos;
  logic [3:0]        page_sel;
  logic [7:0]        col_sel;
  logic [1:0]        n_dec;
  logic              ign_dec;
  logic              rd_dec;
  logic [ADDR_W-1:0] base;

  // memory port
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [7:0]        mem_wdata;
  logic [7:0]        mem_rdata;

  always_comb begin
    off      = item.y[2:0];
    m_dec    = {16'h0000, 8'hFF} << off;
    d_dec    = {8'h00, item.glyph_lower, item.glyph_upper} << off;
    col_pos  = {1'b0, item.x} + {5'b0_0000, item.column_index};
    page_sel = {1'b0, item.y[5:3]};
    col_sel  = {1'b0, item.x};
    n_dec    = 2'd0;
    ign_dec  = 1'b0;
    rd_dec   = 1'b0;
    case (item.operation)
      OP_POINT: begin
        m_dec[0] = 8'h01 << off;
        d_dec[0] = item.pixel_on ? (8'h01 << off) : 8'h00;
        if (({2'b00, item.x} < 9'(COLUMNS)) && ({2'b00, item.y} < 8'(ROWS))) begin
          n_dec = 2'd1;
        end
      end
      OP_GLYPH: begin
        col_sel = col_pos;
        if (({2'b00, item.x} > 9'(COLUMNS - 9)) ||
            (({2'b00, item.y} + 8'd16) >= 8'(ROWS))) begin
          ign_dec = 1'b1;
        end else if ({1'b0, col_pos} < 9'(COLUMNS)) begin
          n_dec = (off == 3'd0) ? 2'd2 : 2'd3;
        end
      end
      OP_READ: begin
        rd_dec   = 1'b1;
        page_sel = {1'b0, item.read_page};
        if (({2'b00, item.read_page} < 5'(PAGES)) && ({2'b00, item.x} < 9'(COLUMNS))) begin
          n_dec = 2'd1;
        end
      end
      default: begin
        n_dec = 2'd0;
      end
    endcase
    base = ADDR_W'(ADDR_W'(page_sel) * ADDR_W'(COLUMNS)) + ADDR_W'(col_sel);
  end

  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_ACCESS) && (issue_cnt == 2'd0) && !pend;
  assign res       = '{read_data: res_data, ignored: res_ign};

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wr_addr;
    mem_wdata = (mem_rdata & ~mask_q[0]) | data_q[0];
    if (state == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = 8'h00;
    end else if ((state == S_ACCESS) && pend && !is_read) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      clr_reply <= 1'b0;
      issue_cnt <= 2'd0;
      pend      <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            res_data <= 8'h00;
            res_ign  <= ign_dec;
            if (item.operation == OP_CLEAR) begin
              state     <= S_CLEAR;
              clr_addr  <= '0;
              clr_reply <= 1'b1;
            end else begin
              state     <= S_ACCESS;
              issue_cnt <= n_dec;
              rd_addr   <= base;
              is_read   <= rd_dec;
              mask_q    <= m_dec;
              data_q    <= d_dec;
            end
          end
        end
        S_ACCESS: begin
          // issue the next read while writing back the byte read last cycle
          pend <= (issue_cnt != 2'd0);
          if (issue_cnt != 2'd0) begin
            issue_cnt <= issue_cnt - 2'd1;
            rd_addr   <= rd_addr + ADDR_W'(COLUMNS);
            wr_addr   <= rd_addr;
          end
          if (pend) begin
            mask_q <= {8'h00, mask_q[2:1]};
            data_q <= {8'h00, data_q[2:1]};
            if (is_read) begin
              res_data <= mem_rdata;
            end
          end
          if (res_valid && res_ready) begin
            state <= S_IDLE;
          end
        end
        S_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == ADDR_W'(DEPTH - 1)) begin
            state <= clr_reply ? S_ACCESS : S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  pfgp_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_frame_store (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(rd_addr),
    .rdata(mem_rdata)
  );

endmodule

// ===== rtl/core/page_framebuffer_glyph_plotter.sv =====
// Monochrome page-layout framebuffer with a glyph-column plotter.
// Input channel (in_valid/in_ready) carries one operation per transaction:
// clear all, draw point, plot one glyph column, or read one stored byte.
// Output channel (out_valid/out_ready) returns exactly one result transaction
// per input: read_data (byte on a read, zero otherwise) and ignored (glyph
// origin out of bounds).
// Items are handled one at a time; each byte a point or glyph stores is a
// read-modify-write on the single frame memory (one read and one write port,
// registered read). A point or read touches one byte, a glyph column two
// (origin row a multiple of 8) or three, a clear all PAGES*COLUMNS bytes; a
// rejected glyph or an out-of-range point or read touches none.
// A result appears on out_valid in the same cycle that in_ready returns.
// Reset starts a clearing pass over all PAGES*COLUMNS bytes with in_ready
// low; after it the image is all dark.
// A stalled receiver holds the result in the output register; the block
// finishes the next item and waits with in_ready low until the slot drains.
module page_framebuffer_glyph_plotter #(
  parameter int COLUMNS = pfgp_pkg::COLUMNS_DEF,
  parameter int PAGES   = pfgp_pkg::PAGES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] operation,
  input  logic [6:0] x,
  input  logic [5:0] y,
  input  logic       pixel_on,
  input  logic [2:0] column_index,
  input  logic [7:0] glyph_upper,
  input  logic [7:0] glyph_lower,
  input  logic [2:0] read_page,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] read_data,
  output logic       ignored
);

  import pfgp_pkg::*;

  item_t   item;
  result_t res;
  logic    res_valid;
  logic    res_ready;

  // Pack the input fields for the sequencer
  assign item = '{
    operation:    operation,
    x:            x,
    y:            y,
    pixel_on:     pixel_on,
    column_index: column_index,
    glyph_upper:  glyph_upper,
    glyph_lower:  glyph_lower,
    read_page:    read_page
  };

  // Output slot is free when empty or draining this cycle
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Load the result payload when a new result enters the slot
  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      read_data <= res.read_data;
      ignored   <= res.ignored;
    end
  end

  pfgp_ctrl #(
    .COLUMNS(COLUMNS),
    .PAGES  (PAGES)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .item     (item),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

endmodule

// ===== verif/tb_page_framebuffer_glyph_plotter.sv =====
module tb_page_framebuffer_glyph_plotter;
  timeunit 1ns;
  timeprecision 1ps;

  import pfgp_pkg::*;

  // Image geometry at the block's default sizes
  localparam int IMG_COLUMNS = COLUMNS_DEF;
  localparam int IMG_PAGES   = PAGES_DEF;
  localparam int IMG_ROWS    = IMG_PAGES * 8;
  localparam int GLYPH_COLS  = 8;
  localparam int GLYPH_ROWS  = 16;

  // Run control
  localparam int RANDOM_PER_PHASE = 310;
  localparam int LONG_HOLD_CYCLES = 200;
  localparam int TAIL_CYCLES      = 20;
  // A clear walks 1024 bytes and the reset clearing pass does the same; a long
  // receiver hold comes on top of that.
  localparam int WATCHDOG_LIMIT   = 8000;
  localparam int MAX_REPORTS      = 10;

  typedef struct {
    item_t   stim;
    bit      typed;
    result_t want;
  } directed_row_t;

  typedef struct {
    logic [2:0] page;
    logic [6:0] column;
  } spot_t;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  item_t      cur_item;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] read_data;
  logic       ignored;

  // Predictor copy of the frame memory, one byte per (page, column)
  logic [7:0]    frame_image [IMG_PAGES * IMG_COLUMNS];
  result_t       pending_results [$];
  spot_t         touched_spots [$];
  directed_row_t directed_rows [$];

  int send_idle_pct;
  int recv_idle_pct;
  int hold_ready_left;
  int idle_cycles;
  int mismatches;
  int results_checked;
  int op_count [4];
  int rejected_glyphs;
  int nonzero_reads;

  page_framebuffer_glyph_plotter i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .operation    (cur_item.operation),
    .x            (cur_item.x),
    .y            (cur_item.y),
    .pixel_on     (cur_item.pixel_on),
    .column_index (cur_item.column_index),
    .glyph_upper  (cur_item.glyph_upper),
    .glyph_lower  (cur_item.glyph_lower),
    .read_page    (cur_item.read_page),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .read_data    (read_data),
    .ignored      (ignored)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Image predictor
  // ---------------------------------------------------------------------------

  // Light or darken one pixel; drop anything that falls off the image.
  function automatic void set_image_pixel(input int px, input int py, input bit on);
    int idx;
    if (px < 0 || px > IMG_COLUMNS - 1 || py < 0 || py > IMG_ROWS - 1) begin
      return;
    end
    idx = (py / 8) * IMG_COLUMNS + px;
    frame_image[idx][py % 8] = on;
  endfunction

  // Apply one operation to the predicted image and return the result it gives.
  function automatic result_t apply_to_image(input item_t it);
    result_t res;
    int      px;
    res = '0;
    case (it.operation)
      OP_CLEAR: begin
        foreach (frame_image[i]) frame_image[i] = 8'h00;
      end
      OP_POINT: begin
        set_image_pixel(int'(it.x), int'(it.y), it.pixel_on);
      end
      OP_GLYPH: begin
        // Reject the whole column when the character origin leaves no room
        if (int'(it.x) > IMG_COLUMNS - 1 - GLYPH_COLS ||
            int'(it.y) > IMG_ROWS - 1 - GLYPH_ROWS) begin
          res.ignored = 1'b1;
        end else begin
          px = int'(it.x) + int'(it.column_index);
          // Upper byte writes ones and zeros; lower byte only lights pixels
          for (int j = 0; j < 8; j++) begin
            set_image_pixel(px, int'(it.y) + j, it.glyph_upper[j]);
          end
          for (int j = 0; j < 8; j++) begin
            if (it.glyph_lower[j]) set_image_pixel(px, int'(it.y) + 8 + j, 1'b1);
          end
        end
      end
      OP_READ: begin
        if (int'(it.read_page) < IMG_PAGES && int'(it.x) < IMG_COLUMNS) begin
          res.read_data = frame_image[int'(it.read_page) * IMG_COLUMNS + int'(it.x)];
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  task automatic add_row(input logic [1:0] op, input int px, input int py, input bit on,
                         input int col, input logic [7:0] upper, input logic [7:0] lower,
                         input int page, input bit typed, input logic [7:0] want_data,
                         input bit want_ignored);
    directed_row_t row;
    row.stim.operation    = op;
    row.stim.x            = px[6:0];
    row.stim.y            = py[5:0];
    row.stim.pixel_on     = on;
    row.stim.column_index = col[2:0];
    row.stim.glyph_upper  = upper;
    row.stim.glyph_lower  = lower;
    row.stim.read_page    = page[2:0];
    row.typed             = typed;
    row.want.read_data    = want_data;
    row.want.ignored      = want_ignored;
    directed_rows.push_back(row);
  endtask

  // Remember a byte that was just written, so later reads can land on it.
  function automatic void note_spot(input int page, input int column);
    spot_t s;
    if (page > IMG_PAGES - 1 || column > IMG_COLUMNS - 1) return;
    s.page   = page[2:0];
    s.column = column[6:0];
    touched_spots.push_back(s);
    if (touched_spots.size() > 32) void'(touched_spots.pop_front());
  endfunction

  // Mostly in-range glyph columns, points and reads of recently written bytes;
  // unused fields carry random noise. A clear shows up now and then.
  function automatic item_t random_item();
    item_t it;
    int    pick;
    spot_t s;
    it.operation    = OP_READ;
    it.x            = 7'($urandom_range(0, 127));
    it.y            = 6'($urandom_range(0, 63));
    it.pixel_on     = 1'($urandom_range(0, 1));
    it.column_index = 3'($urandom_range(0, 7));
    it.glyph_upper  = 8'($urandom_range(0, 255));
    it.glyph_lower  = 8'($urandom_range(0, 255));
    it.read_page    = 3'($urandom_range(0, 7));
    pick = $urandom_range(0, 199);
    if (pick == 0) begin
      it.operation = OP_CLEAR;
    end else if (pick < 51) begin
      it.operation = OP_POINT;
      note_spot(int'(it.y) / 8, int'(it.x));
    end else if (pick < 121) begin
      it.operation = OP_GLYPH;
      if ($urandom_range(0, 9) != 0) begin
        it.x = 7'($urandom_range(0, IMG_COLUMNS - 1 - GLYPH_COLS));
        it.y = 6'($urandom_range(0, IMG_ROWS - 1 - GLYPH_ROWS));
        for (int p = int'(it.y) / 8; p <= (int'(it.y) + GLYPH_ROWS - 1) / 8; p++) begin
          note_spot(p, int'(it.x) + int'(it.column_index));
        end
      end
    end else if (touched_spots.size() != 0 && $urandom_range(0, 9) < 7) begin
      s = touched_spots[$urandom_range(0, touched_spots.size() - 1)];
      it.x         = s.column;
      it.read_page = s.page;
    end
    return it;
  endfunction

  // Offer one transaction after a random gap, hold it until accepted, then
  // record what it should return.
  task automatic drive_item(input item_t it, input bit typed, input result_t want);
    result_t model_res;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    cur_item <= it;
    do @(posedge clk); while (!in_ready);
    model_res = apply_to_image(it);
    pending_results.push_back(typed ? want : model_res);
    op_count[it.operation]++;
    if (model_res.ignored) rejected_glyphs++;
  endtask

  // Drop valid and hold off until every outstanding result has come back.
  task automatic settle_all();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  task automatic check_result(input result_t got);
    result_t want;
    if (pending_results.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $display("ERROR: result with nothing outstanding: read_data=%02h ignored=%0b",
                 got.read_data, got.ignored);
      end
      return;
    end
    want = pending_results.pop_front();
    results_checked++;
    if (got.read_data !== want.read_data || got.ignored !== want.ignored) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $display("ERROR: result %0d: read_data exp %02h got %02h, ignored exp %0b got %0b",
                 results_checked, want.read_data, got.read_data, want.ignored, got.ignored);
      end
    end
    if (want.read_data != 8'h00) nonzero_reads++;
  endtask

  // Sample the result channel at the rising edge, before the block updates.
  always @(posedge clk) begin
    result_t got;
    got.read_data = read_data;
    got.ignored   = ignored;
    if (!rst && out_valid && out_ready) check_result(got);
  end

  // Receiver: random back-pressure, or a long hold when one is requested.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_ready_left > 0) begin
        out_ready <= 1'b0;
        hold_ready_left--;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: end the run if no transaction moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("ERROR: no transaction for %0d cycles, %0d results outstanding",
                 idle_cycles, pending_results.size());
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst             = 1'b1;
    in_valid        = 1'b0;
    cur_item        = '0;
    hold_ready_left = 0;
    idle_cycles     = 0;
    mismatches      = 0;
    results_checked = 0;
    rejected_glyphs = 0;
    nonzero_reads   = 0;
    foreach (op_count[i]) op_count[i] = 0;
    foreach (frame_image[i]) frame_image[i] = 8'h00;
    send_idle_pct = 32;
    recv_idle_pct = 73;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table: reads of the reset image at both corners, rejected origins
    // past either bound, the last legal origin with the farthest column, an
    // aligned glyph spanning two pages and an unaligned one spanning three, upper
    // zeros that darken while lower zeros leave pixels lit, a point on and off at
    // the far corner, and a clear followed by a read.
    add_row(OP_READ,    0,  0, 0, 0, 8'h00, 8'h00, 0, 1, 8'h00, 0);
    add_row(OP_READ,  127, 63, 1, 7, 8'hFF, 8'hFF, 7, 1, 8'h00, 0);
    add_row(OP_GLYPH, 120,  0, 1, 0, 8'hFF, 8'hFF, 0, 1, 8'h00, 1);
    add_row(OP_GLYPH,   0, 48, 0, 3, 8'hFF, 8'h00, 0, 1, 8'h00, 1);
    add_row(OP_GLYPH, 127, 63, 1, 7, 8'hFF, 8'hFF, 7, 1, 8'h00, 1);
    add_row(OP_GLYPH, 119, 47, 0, 7, 8'hFF, 8'hFF, 0, 0, 8'h00, 0);
    add_row(OP_READ,  126,  0, 0, 0, 8'h00, 8'h00, 5, 0, 8'h00, 0);
    add_row(OP_READ,  126,  0, 0, 0, 8'h00, 8'h00, 6, 0, 8'h00, 0);
    add_row(OP_READ,  126,  0, 0, 0, 8'h00, 8'h00, 7, 0, 8'h00, 0);
    add_row(OP_GLYPH,   0,  0, 0, 0, 8'hA5, 8'h3C, 0, 0, 8'h00, 0);
    add_row(OP_READ,    0,  0, 0, 0, 8'h00, 8'h00, 0, 0, 8'h00, 0);
    add_row(OP_READ,    0,  0, 0, 0, 8'h00, 8'h00, 1, 0, 8'h00, 0);
    add_row(OP_GLYPH,   0,  0, 1, 0, 8'h00, 8'h00, 0, 0, 8'h00, 0);
    add_row(OP_READ,    0,  0, 0, 0, 8'h00, 8'h00, 0, 0, 8'h00, 0);
    add_row(OP_READ,    0,  0, 0, 0, 8'h00, 8'h00, 1, 0, 8'h00, 0);
    add_row(OP_POINT, 127, 63, 1, 0, 8'h00, 8'h00, 0, 0, 8'h00, 0);
    add_row(OP_READ,  127,  0, 0, 0, 8'h00, 8'h00, 7, 0, 8'h00, 0);
    add_row(OP_POINT, 127, 63, 0, 7, 8'hFF, 8'hFF, 7, 0, 8'h00, 0);
    add_row(OP_READ,  127,  0, 0, 0, 8'h00, 8'h00, 7, 0, 8'h00, 0);
    add_row(OP_GLYPH,   5,  3, 0, 2, 8'h5A, 8'hC3, 0, 0, 8'h00, 0);
    add_row(OP_READ,    7,  0, 0, 0, 8'h00, 8'h00, 0, 0, 8'h00, 0);
    add_row(OP_READ,    7,  0, 0, 0, 8'h00, 8'h00, 1, 0, 8'h00, 0);
    add_row(OP_READ,    7,  0, 0, 0, 8'h00, 8'h00, 2, 0, 8'h00, 0);
    add_row(OP_CLEAR,   0,  0, 0, 0, 8'h00, 8'h00, 0, 1, 8'h00, 0);
    add_row(OP_READ,    7,  0, 0, 0, 8'h00, 8'h00, 1, 1, 8'h00, 0);

    foreach (directed_rows[i]) begin
      drive_item(directed_rows[i].stim, directed_rows[i].typed, directed_rows[i].want);
    end

    // Random phase with a slow receiver; pause until drained afterwards.
    for (int i = 0; i < RANDOM_PER_PHASE; i++) drive_item(random_item(), 1'b0, '0);
    settle_all();

    // Random phase with a slow sender.
    send_idle_pct = 73;
    recv_idle_pct = 32;
    for (int i = 0; i < RANDOM_PER_PHASE; i++) drive_item(random_item(), 1'b0, '0);
    settle_all();

    // Full rate. Partway through, hold the receiver off for a long stretch so
    // the output slot fills and the block stalls its input.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
      if (i == 50) hold_ready_left = LONG_HOLD_CYCLES;
      drive_item(random_item(), 1'b0, '0);
    end
    settle_all();

    // Let any stray result show up before the verdict.
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d clears, %0d points, %0d glyph columns (%0d rejected), %0d reads",
             op_count[OP_CLEAR], op_count[OP_POINT], op_count[OP_GLYPH], rejected_glyphs,
             op_count[OP_READ]);
    $display("Checked %0d results, %0d with nonzero data, %0d mismatches",
             results_checked, nonzero_reads, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
